>>> src/slfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfs_pkg
// Shared types and constants for the sync/length frame slicer.
// ----------------------------------------------------------------------------
package slfs_pkg;

   localparam int unsigned ByteWidth      = 8;
   localparam int unsigned CsrIndexWidth  = 8;
   localparam int unsigned PosWidth       = 9;
   localparam int unsigned TotalWidth     = 10;
   localparam int unsigned UserWidth      = 3;
   localparam int unsigned FifoDepth      = 4;
   localparam int unsigned FifoPtrWidth   = $clog2(FifoDepth);
   localparam int unsigned FifoCntWidth   = $clog2(FifoDepth + 1);

   localparam int unsigned DefHeaderBytes = 10;
   localparam int unsigned DefCheckBytes  = 2;

   localparam logic [ByteWidth-1:0] SyncReset    = 8'h56;
   localparam logic [ByteWidth-1:0] VersionReset = 8'h02;

   localparam logic [CsrIndexWidth-1:0] CsrSyncValue    = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CsrVersionValue = 8'd1;

   localparam logic [PosWidth-1:0] PosLength = 9'd2;

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_SYNC  = 2'd1,
      PH_FRAME = 2'd2
   } phase_type;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 is_unknown;
      logic                 frame_start;
      logic                 frame_end;
      logic                 step_last;
   } result_type;

endpackage

>>> src/sync_length_frame_slicer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_slicer_unit
// Slices sync/version/length framed packets out of a byte stream.
// ----------------------------------------------------------------------------
// Results of an accepted item are written to the result queue and read out on rsp.
// Throughput: one item per cycle; an item yields 0, 1 or 2 results, drained one per
// cycle while rsp_tready is high through a 4-entry result queue (req_tready while >= 2 free).
// Reset: synchronous, active high; hunting phase, queue empty, registers
// back to sync 0x56 and version 0x02.
module sync_length_frame_slicer_unit #(
   parameter int unsigned HEADER_BYTES = slfs_pkg::DefHeaderBytes,
   parameter int unsigned CHECK_BYTES  = slfs_pkg::DefCheckBytes
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [slfs_pkg::ByteWidth-1:0]      req_tdata,   // in_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slfs_pkg::ByteWidth-1:0]      rsp_tdata,   // out_byte
   output logic [slfs_pkg::UserWidth-1:0]      rsp_tuser,   // is_unknown, frame_start, step_last
   output logic                                rsp_tlast,   // frame_end
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [slfs_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [slfs_pkg::ByteWidth-1:0]      csr_data
);
   import slfs_pkg::*;

   localparam logic [TotalWidth-1:0] FixedBytes = TotalWidth'(HEADER_BYTES + CHECK_BYTES);

   logic [ByteWidth-1:0]    sync_ff, sync_in;
   logic [ByteWidth-1:0]    version_ff, version_in;
   phase_type               phase_ff, phase_in;
   logic [PosWidth-1:0]     pos_ff, pos_in;
   logic [ByteWidth-1:0]    len_ff, len_in;
   logic [ByteWidth-1:0]    held_ff, held_in;

   result_type              fifo_ff [FifoDepth];
   logic [FifoPtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FifoCntWidth-1:0] cnt_ff;

   logic                    req_fire, rsp_fire;
   logic                    sync_hit, ver_hit;
   logic [ByteWidth-1:0]    len_cur;
   logic [TotalWidth-1:0]   total;
   logic                    end_hit;
   result_type              res0, res1;
   logic [1:0]              nres;

   assign req_tready = cnt_ff <= FifoCntWidth'(FifoDepth - 2);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign csr_ready  = 1'b1;

   assign sync_hit = req_tdata == sync_ff;
   assign ver_hit  = req_tdata == version_ff;
   assign len_cur  = (pos_ff == PosLength) ? req_tdata : len_ff;
   assign total    = {{(TotalWidth-ByteWidth){1'b0}}, len_cur} + FixedBytes;
   assign end_hit  = (pos_ff >= PosLength) &&
                     (({1'b0, pos_ff} + TotalWidth'(1)) >= total);

   // configuration
   always_comb begin
      sync_in    = sync_ff;
      version_in = version_ff;
      if (csr_valid) begin
         if (csr_index == CsrSyncValue) begin
            sync_in = csr_data;
         end else if (csr_index == CsrVersionValue) begin
            version_in = csr_data;
         end
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      held_in  = held_ff;
      if (req_fire) begin
         unique case (phase_ff)
            PH_FRAME: begin
               len_in = len_cur;
               if (end_hit) begin
                  phase_in = PH_HUNT;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + PosWidth'(1);
               end
            end
            PH_SYNC: begin
               if (ver_hit) begin
                  phase_in = PH_FRAME;
                  pos_in   = PosLength;
                  len_in   = '0;
               end else if (sync_hit) begin
                  phase_in = PH_SYNC;
                  held_in  = req_tdata;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               if (sync_hit) begin
                  phase_in = PH_SYNC;
                  held_in  = req_tdata;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   // results of the current item
   always_comb begin
      res0 = '0;
      res1 = '0;
      nres = 2'd0;
      unique case (phase_ff)
         PH_FRAME: begin
            res0 = '{out_byte: req_tdata, is_unknown: 1'b0, frame_start: 1'b0,
                     frame_end: end_hit, step_last: 1'b1};
            nres = 2'd1;
         end
         PH_SYNC: begin
            if (ver_hit) begin
               res0 = '{out_byte: held_ff, is_unknown: 1'b0, frame_start: 1'b1,
                        frame_end: 1'b0, step_last: 1'b0};
               res1 = '{out_byte: req_tdata, is_unknown: 1'b0, frame_start: 1'b0,
                        frame_end: 1'b0, step_last: 1'b1};
               nres = 2'd2;
            end else if (sync_hit) begin
               res0 = '{out_byte: held_ff, is_unknown: 1'b1, frame_start: 1'b0,
                        frame_end: 1'b0, step_last: 1'b1};
               nres = 2'd1;
            end else begin
               res0 = '{out_byte: held_ff, is_unknown: 1'b1, frame_start: 1'b0,
                        frame_end: 1'b0, step_last: 1'b0};
               res1 = '{out_byte: req_tdata, is_unknown: 1'b1, frame_start: 1'b0,
                        frame_end: 1'b0, step_last: 1'b1};
               nres = 2'd2;
            end
         end
         default: begin
            if (!sync_hit) begin
               res0 = '{out_byte: req_tdata, is_unknown: 1'b1, frame_start: 1'b0,
                        frame_end: 1'b0, step_last: 1'b1};
               nres = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= SyncReset;
         version_ff <= VersionReset;
         phase_ff   <= PH_HUNT;
         pos_ff     <= '0;
         len_ff     <= '0;
         held_ff    <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         cnt_ff     <= '0;
      end else begin
         sync_ff    <= sync_in;
         version_ff <= version_in;
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         held_ff    <= held_in;
         if (req_fire) begin
            wr_ptr_ff <= wr_ptr_ff + FifoPtrWidth'(nres);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + FifoPtrWidth'(1);
         end
         cnt_ff <= cnt_ff + (req_fire ? FifoCntWidth'(nres) : FifoCntWidth'(0))
                          - (rsp_fire ? FifoCntWidth'(1) : FifoCntWidth'(0));
      end
   end

   // result queue payload
   always_ff @(posedge clock) begin
      if (req_fire && nres != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
         if (nres == 2'd2) begin
            fifo_ff[wr_ptr_ff + FifoPtrWidth'(1)] <= res1;
         end
      end
   end

   assign rsp_tdata = fifo_ff[rd_ptr_ff].out_byte;
   assign rsp_tuser = {fifo_ff[rd_ptr_ff].step_last,
                       fifo_ff[rd_ptr_ff].frame_start,
                       fifo_ff[rd_ptr_ff].is_unknown};
   assign rsp_tlast = fifo_ff[rd_ptr_ff].frame_end;

endmodule

>>> test/sync_length_frame_slicer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_slicer_unit_test
// Self-checking bench for the frame slicer. A directed table covers reset
// values, hunting, rejected and repeated sync bytes, a full short frame and a
// sync byte held across a register change. Random phases follow, mostly
// well-formed frames mixed with noise and broken headers, under several
// register settings. Stalls on both sides, including one long receiver hold.
// Every result is checked against the directed table or a local model of the slicer.
// ----------------------------------------------------------------------------
module sync_length_frame_slicer_unit_test;
   import slfs_pkg::*;

   localparam int HeaderBytes = DefHeaderBytes;
   localparam int CheckBytes  = DefCheckBytes;
   localparam int Predicted   = -1;
   localparam int PhaseItems  = 210;
   localparam int LongHold    = 300;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [ByteWidth-1:0]  data;
      logic [CsrIndexWidth-1:0] index;
      int                    n_typed;
      result_type            e0;
      result_type            e1;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [ByteWidth-1:0]     req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [ByteWidth-1:0]     rsp_tdata;
   logic [UserWidth-1:0]     rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [ByteWidth-1:0]     csr_data;

   // slicer model state
   phase_type            sl_phase;
   logic [PosWidth-1:0]  sl_pos;
   logic [ByteWidth-1:0] sl_len;
   logic [ByteWidth-1:0] sl_held;
   logic [ByteWidth-1:0] sl_sync;
   logic [ByteWidth-1:0] sl_version;
   result_type           sliced [2];
   int                   sliced_count;

   result_type   expected_slices [$];
   stim_row_type stim_rows [$];

   int fail_count;
   int mismatch_count;
   bit tx_idle_on;
   bit rx_idle_on;
   bit stall_request;
   int hold_left;

   sync_length_frame_slicer_unit #(
      .HEADER_BYTES(HeaderBytes),
      .CHECK_BYTES (CheckBytes)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[sync_length_frame_slicer_unit] ERROR");
      $finish;
   end

   function automatic result_type res(input logic [ByteWidth-1:0] b, input logic unk,
                                      input logic st, input logic en, input logic last);
      result_type r;
      r.out_byte    = b;
      r.is_unknown  = unk;
      r.frame_start = st;
      r.frame_end   = en;
      r.step_last   = last;
      return r;
   endfunction

   function automatic void add_row(input row_kind_type kind, input logic [ByteWidth-1:0] data,
                                   input logic [CsrIndexWidth-1:0] index, input int n_typed,
                                   input result_type e0, input result_type e1);
      stim_row_type row;
      row.kind    = kind;
      row.data    = data;
      row.index   = index;
      row.n_typed = n_typed;
      row.e0      = e0;
      row.e1      = e1;
      stim_rows.push_back(row);
   endfunction

   function automatic void slice_byte(input logic [ByteWidth-1:0] b);
      int  total;
      logic endf;
      sliced_count = 0;
      sliced[0]    = '0;
      sliced[1]    = '0;
      if (sl_phase == PH_FRAME) begin
         if (sl_pos == PosLength) sl_len = b;
         total = HeaderBytes + int'(sl_len) + CheckBytes;
         endf  = (sl_pos >= PosLength) && (int'(sl_pos) + 1 >= total);
         sliced[0]    = res(b, 1'b0, 1'b0, endf, 1'b0);
         sliced_count = 1;
         if (endf) begin
            sl_phase = PH_HUNT;
            sl_pos   = '0;
         end else begin
            sl_pos = sl_pos + PosWidth'(1);
         end
      end else begin
         if (sl_phase == PH_SYNC) begin
            if (b == sl_version) begin
               sliced[0]    = res(sl_held, 1'b0, 1'b1, 1'b0, 1'b0);
               sliced[1]    = res(b, 1'b0, 1'b0, 1'b0, 1'b1);
               sliced_count = 2;
               sl_phase     = PH_FRAME;
               sl_pos       = PosLength;
               sl_len       = '0;
               return;
            end
            sliced[0]    = res(sl_held, 1'b1, 1'b0, 1'b0, 1'b0);
            sliced_count = 1;
         end
         sl_phase = PH_HUNT;
         if (b == sl_sync) begin
            sl_held  = b;
            sl_phase = PH_SYNC;
         end else begin
            sliced[sliced_count] = res(b, 1'b1, 1'b0, 1'b0, 1'b0);
            sliced_count++;
         end
      end
      if (sliced_count > 0) sliced[sliced_count-1].step_last = 1'b1;
   endfunction

   task automatic send_item(input logic [ByteWidth-1:0] b, input int n_typed = Predicted,
                            input result_type e0 = '0, input result_type e1 = '0);
      if (tx_idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      slice_byte(b);
      if (n_typed == Predicted) begin
         for (int k = 0; k < sliced_count; k++) expected_slices.push_back(sliced[k]);
      end else begin
         if (n_typed > 0) expected_slices.push_back(e0);
         if (n_typed > 1) expected_slices.push_back(e1);
      end
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] index,
                            input logic [ByteWidth-1:0] data);
      req_tvalid <= 1'b0;
      while (expected_slices.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == CsrSyncValue) sl_sync = data;
      else if (index == CsrVersionValue) sl_version = data;
   endtask

   task automatic run_phase(input logic [ByteWidth-1:0] sync_cfg,
                            input logic [ByteWidth-1:0] version_cfg,
                            input bit tx_idle, input bit rx_idle, input bit pressure);
      int                   sent;
      int                   pick;
      int                   len;
      logic [ByteWidth-1:0] b2;
      write_csr(CsrSyncValue, sync_cfg);
      write_csr(CsrVersionValue, version_cfg);
      tx_idle_on = tx_idle;
      rx_idle_on = rx_idle;
      if (pressure) stall_request = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
            send_item(sl_sync);
            send_item(sl_version);
            send_item(len[ByteWidth-1:0]);
            repeat (HeaderBytes - 3 + len + CheckBytes)
               send_item(ByteWidth'($urandom_range(0, 255)));
            sent += HeaderBytes + len + CheckBytes;
         end else if (pick < 85) begin
            len = $urandom_range(1, 4);
            repeat (len) send_item(ByteWidth'($urandom_range(0, 255)));
            sent += len;
         end else begin
            b2 = ByteWidth'($urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0) b2 = sl_sync;
            if (b2 == sl_version) b2 = sl_version ^ 8'h01;
            send_item(sl_sync);
            send_item(b2);
            sent += 2;
         end
      end
   endtask

   // result side: random tready bursts, one long hold on request
   initial begin
      rsp_tready <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left     = LongHold;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 11);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = res(rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast, rsp_tuser[2]);
         if (expected_slices.size() == 0) begin
            fail_count++;
            if (mismatch_count < 10)
               $display("unexpected item: byte %02h unk %0b start %0b end %0b last %0b",
                        got.out_byte, got.is_unknown, got.frame_start, got.frame_end,
                        got.step_last);
            mismatch_count++;
         end else begin
            want = expected_slices.pop_front();
            if (got.out_byte != want.out_byte || got.is_unknown != want.is_unknown ||
                got.frame_start != want.frame_start || got.frame_end != want.frame_end ||
                got.step_last != want.step_last) begin
               fail_count++;
               if (mismatch_count < 10)
                  $display("mismatch: exp %02h u%0b s%0b e%0b l%0b, got %02h u%0b s%0b e%0b l%0b",
                           want.out_byte, want.is_unknown, want.frame_start, want.frame_end,
                           want.step_last, got.out_byte, got.is_unknown, got.frame_start,
                           got.frame_end, got.step_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int wait_cycles;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_data      <= '0;
      fail_count     = 0;
      mismatch_count = 0;
      tx_idle_on     = 1'b1;
      rx_idle_on     = 1'b1;
      stall_request  = 1'b0;
      sl_phase       = PH_HUNT;
      sl_pos         = '0;
      sl_len         = '0;
      sl_held        = '0;
      sl_sync        = SyncReset;
      sl_version     = VersionReset;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hunting with reset registers
      add_row(ROW_ITEM, 8'h00, '0, 1, res(8'h00, 1'b1, 1'b0, 1'b0, 1'b1), '0);
      add_row(ROW_ITEM, 8'hFF, '0, 1, res(8'hFF, 1'b1, 1'b0, 1'b0, 1'b1), '0);
      add_row(ROW_ITEM, 8'h56, '0, 0, '0, '0);
      add_row(ROW_ITEM, 8'h33, '0, 2, res(8'h56, 1'b1, 1'b0, 1'b0, 1'b0),
              res(8'h33, 1'b1, 1'b0, 1'b0, 1'b1));
      // sync after a failed version is held again
      add_row(ROW_ITEM, 8'h56, '0, 0, '0, '0);
      add_row(ROW_ITEM, 8'h56, '0, 1, res(8'h56, 1'b1, 1'b0, 1'b0, 1'b1), '0);
      add_row(ROW_ITEM, 8'h02, '0, 2, res(8'h56, 1'b0, 1'b1, 1'b0, 1'b0),
              res(8'h02, 1'b0, 1'b0, 1'b0, 1'b1));
      // empty payload frame
      add_row(ROW_ITEM, 8'h00, '0, Predicted, '0, '0);
      add_row(ROW_ITEM, 8'hFF, '0, Predicted, '0, '0);
      add_row(ROW_ITEM, 8'h56, '0, Predicted, '0, '0);
      add_row(ROW_ITEM, 8'h02, '0, Predicted, '0, '0);
      add_row(ROW_ITEM, 8'hAA, '0, Predicted, '0, '0);
      add_row(ROW_ITEM, 8'h55, '0, Predicted, '0, '0);
      add_row(ROW_ITEM, 8'h01, '0, Predicted, '0, '0);
      add_row(ROW_ITEM, 8'h80, '0, Predicted, '0, '0);
      add_row(ROW_ITEM, 8'h7F, '0, Predicted, '0, '0);
      add_row(ROW_ITEM, 8'hC3, '0, 1, res(8'hC3, 1'b0, 1'b0, 1'b1, 1'b1), '0);
      // held sync survives a register change and keeps its value
      add_row(ROW_ITEM, 8'h56, '0, 0, '0, '0);
      add_row(ROW_CSR, 8'h00, CsrSyncValue, 0, '0, '0);
      add_row(ROW_CSR, 8'hFF, CsrVersionValue, 0, '0, '0);
      add_row(ROW_ITEM, 8'hFF, '0, 2, res(8'h56, 1'b0, 1'b1, 1'b0, 1'b0),
              res(8'hFF, 1'b0, 1'b0, 1'b0, 1'b1));
      // longest payload, filled by the random part
      add_row(ROW_ITEM, 8'hFF, '0, Predicted, '0, '0);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR)
            write_csr(stim_rows[i].index, stim_rows[i].data);
         else
            send_item(stim_rows[i].data, stim_rows[i].n_typed, stim_rows[i].e0,
                      stim_rows[i].e1);
      end

      run_phase(SyncReset, VersionReset, 1'b1, 1'b1, 1'b0);
      run_phase(8'hFF, 8'h00, 1'b1, 1'b0, 1'b0);
      run_phase(ByteWidth'($urandom_range(0, 255)), ByteWidth'($urandom_range(0, 255)),
                1'b0, 1'b1, 1'b0);
      run_phase(ByteWidth'($urandom_range(0, 255)), ByteWidth'($urandom_range(0, 255)),
                1'b1, 1'b1, 1'b1);
      b_same: begin
         logic [ByteWidth-1:0] same;
         same = ByteWidth'($urandom_range(0, 255));
         run_phase(same, same, 1'b1, 1'b1, 1'b0);
      end
      run_phase(8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
      run_phase(SyncReset, VersionReset, 1'b0, 1'b0, 1'b0);
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (expected_slices.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (expected_slices.size() != 0) begin
         fail_count++;
         $display("%0d expected items never arrived", expected_slices.size());
      end
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[sync_length_frame_slicer_unit] OK");
      end else begin
         $display("[sync_length_frame_slicer_unit] ERROR");
      end
      $finish;
   end

endmodule
